>>> src/imufp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the IMU frame parser.
// No dependencies; imported by imu_frame_parser_unit.
package imufp_pkg;

    localparam int unsigned STORE_DEPTH = 44;
    localparam int unsigned ADDR_W      = 6;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned OUT_TUSER_W = 6;
    localparam int unsigned IN_TDATA_W  = 8;

    localparam logic [7:0] ID_CONTROL  = 8'h01;
    localparam logic [7:0] ID_INERTIAL = 8'h02;

    // Body lengths count from the sync byte and exclude the checksum word.
    localparam logic [ADDR_W-1:0] BODY_CONTROL  = 6'd18;
    localparam logic [ADDR_W-1:0] BODY_INERTIAL = 6'd42;

    localparam logic [ADDR_W-1:0] FIRST_FIELD_ADDR = 6'd2;

    localparam logic [3:0] LAST_FIELD_CONTROL  = 4'd7;
    localparam logic [3:0] LAST_FIELD_INERTIAL = 4'd13;
    localparam logic [3:0] FIRST_STATUS_FIELD  = 4'd6;
    localparam logic [3:0] FIRST_DELTA_FIELD   = 4'd8;

    localparam logic [7:0]  SYNC_RESET = 8'h0E;
    localparam logic        EMIT_RESET = 1'b1;

    typedef enum logic {
        CFG_SYNC_VALUE = 1'b0,
        CFG_EMIT_BAD   = 1'b1
    } t_cfg_idx;

    typedef logic [ADDR_W-1:0] t_addr;

endpackage

>>> src/imu_frame_parser_unit.sv
`timescale 1ns / 1ps
// Byte-serial deframer for the two-message IMU protocol, with its frame buffer.
// Depends on imufp_pkg.

// The block takes one received byte per cycle while it hunts for sync, waits for the
// message ID and collects the frame, keeping the 16-bit word sum on the fly. After the
// last byte of a frame that passes the checksum (or of any frame, when bad frames are
// emitted), the fields are read back out of the 44-byte frame buffer through its single
// read port, one byte per cycle. After the bytes of each field a wait state lets the last
// byte reach the accumulator, and a load state moves the field into the output register
// once the output side is free; no input is taken until the last field is loaded. The
// last field stays in the output register while new bytes are already accepted.
module imu_frame_parser_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [7:0]                          i_cfg_wdata,
    // Input stream: tdata[7:0] = rx_byte.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [imufp_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // Output stream: tdata[31:0] = field_value.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [imufp_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // tuser[0] = frame_kind, [1] = sum_ok, [5:2] = field_index.
    output logic [imufp_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    import imufp_pkg::*;

    typedef enum logic [2:0] {
        S_HUNT,
        S_ID,
        S_BODY,
        S_READ,
        S_WAIT,
        S_LOAD
    } t_state;

    t_state       r_state;
    logic [7:0]   r_sync_value;
    logic         r_emit_bad;
    t_addr        r_count;
    logic         r_kind;
    logic         r_ok;
    logic [15:0]  r_sum;
    logic [7:0]   r_first;
    logic [7:0]   r_prev;

    // Read sequencer.
    t_addr        r_rd_addr;
    logic [1:0]   r_byte_sel;
    logic [3:0]   r_field;
    logic         r_rd_vld_d;
    logic [1:0]   r_sel_d;
    logic [31:0]  r_acc;

    // Frame buffer.
    logic [7:0]   r_mem [STORE_DEPTH];
    logic [7:0]   r_mem_q;

    // Output register.
    logic         r_out_valid;
    logic         r_out_kind;
    logic         r_out_ok;
    logic [3:0]   r_out_idx;
    logic [31:0]  r_out_value;
    logic         r_out_last;

    logic         s_take;
    logic [7:0]   rx_byte;
    logic         is_sync;
    logic         is_id;
    t_addr        body_len;
    logic         is_final;
    logic         chk_ok;
    logic [1:0]   sel_last;
    logic [3:0]   field_last;
    logic [31:0]  field_val;
    logic         mem_we;
    t_addr        mem_waddr;
    logic [15:0]  sum_add;

    assign o_s_axis_tready = (r_state == S_HUNT) || (r_state == S_ID) || (r_state == S_BODY);
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;
    assign rx_byte         = i_s_axis_tdata[7:0];
    assign is_sync         = (rx_byte == r_sync_value);
    assign is_id           = (rx_byte == ID_CONTROL) || (rx_byte == ID_INERTIAL);
    assign body_len        = r_kind ? BODY_INERTIAL : BODY_CONTROL;
    assign is_final        = (r_count == body_len + t_addr'(1));
    assign chk_ok          = (r_sum == {rx_byte, r_prev});
    assign sel_last        = (r_field < FIRST_DELTA_FIELD) ? 2'd1 : 2'd3;
    assign field_last      = r_kind ? LAST_FIELD_INERTIAL : LAST_FIELD_CONTROL;
    assign sum_add         = r_count[0] ? {rx_byte, 8'h00} : {8'h00, rx_byte};

    always_comb begin
        if (r_field < FIRST_STATUS_FIELD) begin
            field_val = {{16{r_acc[15]}}, r_acc[15:0]};
        end else if (r_field < FIRST_DELTA_FIELD) begin
            field_val = {16'h0000, r_acc[15:0]};
        end else begin
            field_val = r_acc;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        case (r_state)
            S_HUNT: begin
                mem_we = s_take && is_sync;
            end
            S_ID: begin
                mem_we    = s_take && (is_sync || is_id);
                mem_waddr = is_sync ? t_addr'(0) : t_addr'(1);
            end
            S_BODY: begin
                mem_we    = s_take;
                mem_waddr = r_count;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= rx_byte;
        end
        r_mem_q <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_HUNT;
            r_sync_value <= SYNC_RESET;
            r_emit_bad   <= EMIT_RESET;
            r_count      <= '0;
            r_kind       <= 1'b0;
            r_sum        <= '0;
            r_rd_vld_d   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_SYNC_VALUE: r_sync_value <= i_cfg_wdata;
                    CFG_EMIT_BAD:   r_emit_bad   <= i_cfg_wdata[0];
                    default:        r_emit_bad   <= r_emit_bad;
                endcase
            end

            if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            r_rd_vld_d <= (r_state == S_READ);
            r_sel_d    <= r_byte_sel;
            if (r_rd_vld_d) begin
                r_acc[8*r_sel_d +: 8] <= r_mem_q;
            end

            case (r_state)
                S_HUNT: begin
                    if (s_take && is_sync) begin
                        r_first <= rx_byte;
                        r_state <= S_ID;
                    end
                end
                S_ID: begin
                    if (s_take) begin
                        if (is_sync) begin
                            r_first <= rx_byte;
                        end else if (is_id) begin
                            r_kind  <= (rx_byte == ID_INERTIAL);
                            r_sum   <= {rx_byte, r_first};
                            r_count <= t_addr'(2);
                            r_state <= S_BODY;
                        end else begin
                            r_state <= S_HUNT;
                        end
                    end
                end
                S_BODY: begin
                    if (s_take) begin
                        r_prev  <= rx_byte;
                        r_count <= r_count + t_addr'(1);
                        if (r_count < body_len) begin
                            r_sum <= r_sum + sum_add;
                        end
                        if (is_final) begin
                            r_count    <= '0;
                            r_ok       <= chk_ok;
                            r_rd_addr  <= FIRST_FIELD_ADDR;
                            r_byte_sel <= '0;
                            r_field    <= '0;
                            r_state    <= (chk_ok || r_emit_bad) ? S_READ : S_HUNT;
                        end
                    end
                end
                S_READ: begin
                    r_rd_addr  <= r_rd_addr + t_addr'(1);
                    r_byte_sel <= r_byte_sel + 2'd1;
                    if (r_byte_sel == sel_last) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_kind;
                        r_out_ok    <= r_ok;
                        r_out_idx   <= r_field;
                        r_out_value <= field_val;
                        r_out_last  <= (r_field == field_last);
                        r_byte_sel  <= '0;
                        r_field     <= r_field + 4'd1;
                        r_state     <= (r_field == field_last) ? S_HUNT : S_READ;
                    end
                end
                default: begin
                    r_state <= S_HUNT;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = {r_out_idx, r_out_ok, r_out_kind};
    assign o_m_axis_tlast  = r_out_last;

    // The final field of a frame carries the index that matches its kind.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            ((r_out_idx == LAST_FIELD_CONTROL && !r_out_kind) ||
             (r_out_idx == LAST_FIELD_INERTIAL && r_out_kind)))
        else $error("last field index does not match frame kind");

    // The byte counter never runs past the frame buffer.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < t_addr'(STORE_DEPTH))
        else $error("byte count beyond frame buffer");

    // Inside a frame body at least the sync and ID bytes have been stored.
    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BODY) |-> (r_count >= t_addr'(2)))
        else $error("frame body entered without sync and ID");

    // A field is only loaded once its last byte has reached the accumulator.
    a_load_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_state == S_LOAD)) |-> ($past(r_state) == S_WAIT))
        else $error("field loaded before its bytes were read");

endmodule

>>> tb/sv/imu_frame_parser_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for imu_frame_parser_unit: it streams bytes, predicts the
// emitted frame fields and compares each output word with the prediction.
// Depends on imufp_pkg and imu_frame_parser_unit.
module imu_frame_parser_unit_tb;
    import imufp_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 90;

    typedef enum logic [1:0] {
        HUNT_SYNC = 2'd0,
        WAIT_ID   = 2'd1,
        IN_FRAME  = 2'd2
    } t_parse_phase;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_EDGE,
        FILL_SYNC
    } t_fill;

    typedef struct {
        bit          inertial;
        bit          sum_ok;
        logic [3:0]  index;
        logic [31:0] value;
        bit          last;
    } t_field_word;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic                   i_cfg_addr      = 1'b0;
    logic [7:0]             i_cfg_wdata     = 8'h00;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    imu_frame_parser_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Configuration mirror and deframer state of the predictor.
    logic [7:0]   sync_cfg     = SYNC_RESET;
    logic         emit_bad_cfg = EMIT_RESET;
    t_parse_phase parse_phase  = HUNT_SYNC;
    logic [5:0]   frame_pos    = '0;
    bit           frm_inertial = 1'b0;
    logic [15:0]  word_sum     = '0;
    logic [7:0]   frame_bytes [STORE_DEPTH];

    logic [7:0]  rx_bytes [$];
    t_field_word expected_fields [$];

    bit in_fire     = 1'b0;
    int fail_count  = 0;
    int src_gap     = 0;
    int sink_gap    = 0;
    int gap_odds    = 0;
    int stall_odds  = 0;
    int quiet_count = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [15:0] stored_half(int addr);
        return {frame_bytes[addr + 1], frame_bytes[addr]};
    endfunction

    function automatic logic [31:0] frame_field(int f);
        logic [15:0] h;
        if (f < FIRST_STATUS_FIELD) begin
            h = stored_half(FIRST_FIELD_ADDR + 2 * f);
            return {{16{h[15]}}, h};
        end
        if (f < FIRST_DELTA_FIELD)
            return {16'h0000, stored_half(14 + 2 * (f - FIRST_STATUS_FIELD))};
        return {stored_half(20 + 4 * (f - FIRST_DELTA_FIELD)),
                stored_half(18 + 4 * (f - FIRST_DELTA_FIELD))};
    endfunction

    // Advances the deframer by one byte and queues the fields that a completed frame emits.
    function automatic void deframe_byte(logic [7:0] b);
        int          pos;
        int          body;
        int          count;
        bit          ok;
        t_field_word w;
        case (parse_phase)
            WAIT_ID: begin
                if (b == sync_cfg) begin
                    frame_bytes[0] = b;
                end else if (b == ID_CONTROL || b == ID_INERTIAL) begin
                    frm_inertial   = (b == ID_INERTIAL);
                    frame_bytes[1] = b;
                    word_sum       = {b, frame_bytes[0]};
                    frame_pos      = 6'd2;
                    parse_phase    = IN_FRAME;
                end else begin
                    parse_phase = HUNT_SYNC;
                end
            end
            IN_FRAME: begin
                body = int'(frm_inertial ? BODY_INERTIAL : BODY_CONTROL);
                pos  = int'(frame_pos);
                if (pos < STORE_DEPTH)
                    frame_bytes[pos] = b;
                if (pos < body)
                    word_sum = word_sum + (pos[0] ? {b, 8'h00} : {8'h00, b});
                frame_pos = frame_pos + 6'd1;
                if (pos + 1 >= body + 2) begin
                    ok = (word_sum == stored_half(body));
                    if (ok || emit_bad_cfg) begin
                        count = frm_inertial ? LAST_FIELD_INERTIAL + 1 : LAST_FIELD_CONTROL + 1;
                        for (int f = 0; f < count; f++) begin
                            w.inertial = frm_inertial;
                            w.sum_ok   = ok;
                            w.index    = 4'(f);
                            w.value    = frame_field(f);
                            w.last     = (f + 1 == count);
                            expected_fields.push_back(w);
                        end
                    end
                    parse_phase = HUNT_SYNC;
                    frame_pos   = '0;
                end
            end
            default: begin
                if (b == sync_cfg) begin
                    frame_bytes[0] = b;
                    parse_phase    = WAIT_ID;
                end else begin
                    parse_phase = HUNT_SYNC;
                end
            end
        endcase
    endfunction

    // Queues a frame for the current sync value, with a good or a corrupted checksum, less the last cut bytes.
    function automatic int queue_frame(bit inertial, bit good, t_fill fill, int cut);
        logic [7:0]  fr [STORE_DEPTH];
        logic [15:0] w;
        logic [15:0] sum;
        int          len;
        int          body;
        len  = inertial ? BODY_INERTIAL + 2 : BODY_CONTROL + 2;
        body = len - 2;
        fr[0] = sync_cfg;
        fr[1] = inertial ? ID_INERTIAL : ID_CONTROL;
        for (int i = 2; i < body; i += 2) begin
            case (fill)
                FILL_ZERO: w = 16'h0000;
                FILL_ONES: w = 16'hFFFF;
                FILL_EDGE: begin
                    case ($urandom_range(3, 0))
                        0: w = 16'h7FFF;
                        1: w = 16'h8000;
                        2: w = 16'h0000;
                        default: w = 16'hFFFF;
                    endcase
                end
                FILL_SYNC: w = {($urandom_range(1, 0) ? sync_cfg : 8'($urandom)), sync_cfg};
                default: w = 16'($urandom);
            endcase
            fr[i]     = w[7:0];
            fr[i + 1] = w[15:8];
        end
        sum = '0;
        for (int i = 0; i < body; i += 2)
            sum = sum + {fr[i + 1], fr[i]};
        if (!good)
            sum = sum ^ 16'($urandom_range(16'hFFFF, 1));
        fr[body]     = sum[7:0];
        fr[body + 1] = sum[15:8];
        for (int i = 0; i < len - cut; i++)
            rx_bytes.push_back(fr[i]);
        return len - cut;
    endfunction

    function automatic logic [7:0] unknown_id();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == ID_CONTROL || b == ID_INERTIAL || b == sync_cfg);
        return b;
    endfunction

    // Mostly complete frames with random content; the rest are cut frames, repeated
    // sync bytes, unknown IDs and line noise.
    function automatic void random_traffic(int n_bytes);
        int    queued;
        int    pick;
        t_fill fill;
        queued = 0;
        while (queued < n_bytes) begin
            pick = $urandom_range(99, 0);
            fill = ($urandom_range(9, 0) < 6) ? FILL_RANDOM : t_fill'($urandom_range(4, 0));
            if (pick < 68) begin
                queued += queue_frame(1'($urandom_range(1, 0)), $urandom_range(3, 0) != 0,
                                      fill, 0);
            end else if (pick < 78) begin
                queued += queue_frame(1'($urandom_range(1, 0)), 1'b1, fill,
                                      $urandom_range(12, 1));
            end else if (pick < 86) begin
                rx_bytes.push_back(sync_cfg);
                queued += 1 + queue_frame(1'($urandom_range(1, 0)), 1'b1, fill, 0);
            end else if (pick < 93) begin
                rx_bytes.push_back(sync_cfg);
                rx_bytes.push_back(unknown_id());
                queued += 2;
            end else begin
                repeat ($urandom_range(6, 1)) rx_bytes.push_back(8'($urandom));
            end
        end
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_SYNC_VALUE)
            sync_cfg = val;
        else
            emit_bad_cfg = val[0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every byte is taken and every field has come out, then lets a dropped
    // frame finish inside the block.
    task automatic settle();
        while (rx_bytes.size() != 0 || i_s_axis_tvalid || expected_fields.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : scenario
        for (int i = 0; i < STORE_DEPTH; i++)
            frame_bytes[i] = 8'h00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration, directed frames first.
        gap_odds   = 4;
        stall_odds = 4;
        void'(queue_frame(1'b0, 1'b1, FILL_ONES, 0));
        void'(queue_frame(1'b1, 1'b1, FILL_EDGE, 0));
        void'(queue_frame(1'b1, 1'b1, FILL_ZERO, 0));
        rx_bytes.push_back(sync_cfg);           // sync where the ID belongs
        void'(queue_frame(1'b0, 1'b1, FILL_RANDOM, 0));
        rx_bytes.push_back(sync_cfg);
        rx_bytes.push_back(8'h03);              // unknown ID resumes the hunt
        rx_bytes.push_back(sync_cfg);
        rx_bytes.push_back(8'hFF);
        void'(queue_frame(1'b0, 1'b1, FILL_SYNC, 0));
        void'(queue_frame(1'b1, 1'b0, FILL_RANDOM, 0));
        settle();

        // Bad frames are dropped.
        write_reg(CFG_EMIT_BAD, 8'h00);
        gap_odds   = 3;
        stall_odds = 0;
        void'(queue_frame(1'b0, 1'b0, FILL_RANDOM, 0));
        void'(queue_frame(1'b1, 1'b0, FILL_SYNC, 0));
        void'(queue_frame(1'b0, 1'b1, FILL_RANDOM, 0));
        settle();

        write_reg(CFG_SYNC_VALUE, 8'h00);
        write_reg(CFG_EMIT_BAD, 8'h01);
        gap_odds   = 0;
        stall_odds = 3;
        random_traffic(10);
        settle();

        write_reg(CFG_SYNC_VALUE, 8'hFF);
        write_reg(CFG_EMIT_BAD, 8'h00);
        gap_odds   = 5;
        stall_odds = 5;
        random_traffic(10);
        settle();

        // A sync value equal to the control ID keeps control frames from opening.
        write_reg(CFG_SYNC_VALUE, ID_CONTROL);
        write_reg(CFG_EMIT_BAD, 8'h01);
        gap_odds   = 2;
        stall_odds = 2;
        random_traffic(10);
        settle();

        write_reg(CFG_SYNC_VALUE, 8'($urandom));
        write_reg(CFG_EMIT_BAD, 8'($urandom_range(1, 0)));
        gap_odds   = 6;
        stall_odds = 3;
        random_traffic(10);
        settle();

        // Final stretch at full rate on both sides.
        write_reg(CFG_SYNC_VALUE, SYNC_RESET);
        write_reg(CFG_EMIT_BAD, 8'h01);
        gap_odds   = 0;
        stall_odds = 0;
        random_traffic(30);
        settle();

        if (fail_count == 0 && expected_fields.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Byte source: presents the next queued byte, with random gaps between bytes.
    always @(negedge i_clk) begin : byte_source
        logic       nv;
        logic [7:0] nd;
        nv = i_s_axis_tvalid;
        nd = i_s_axis_tdata;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!nv || in_fire) begin
            nv = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
            end else if (rx_bytes.size() != 0) begin
                if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
                    src_gap = $urandom_range(14, 1) - 1;
                end else begin
                    nd = rx_bytes.pop_front();
                    nv = 1'b1;
                end
            end
        end
        i_s_axis_tvalid <= nv;
        i_s_axis_tdata  <= nd;
    end

    // Field sink: holds off the output side in random bursts.
    always @(negedge i_clk) begin : field_sink
        logic r;
        if (sink_gap > 0) begin
            sink_gap--;
            r = 1'b0;
        end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
            sink_gap = $urandom_range(14, 1) - 1;
            r = 1'b0;
        end else begin
            r = 1'b1;
        end
        i_m_axis_tready <= r;
    end

    // Words are printed as kind, sum flag, index, value and last flag.
    always @(posedge i_clk) begin : monitor
        t_field_word exp_w;
        t_field_word got;
        in_fire = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.inertial = o_m_axis_tuser[0];
            got.sum_ok   = o_m_axis_tuser[1];
            got.index    = o_m_axis_tuser[5:2];
            got.value    = o_m_axis_tdata[31:0];
            got.last     = o_m_axis_tlast;
            if (expected_fields.size() == 0) begin
                fail_count++;
                $display("%t: expected no word, got %0d %0d %0d %h %0d",
                         $time, got.inertial, got.sum_ok, got.index, got.value, got.last);
            end else begin
                exp_w = expected_fields.pop_front();
                if (got.inertial !== exp_w.inertial || got.sum_ok !== exp_w.sum_ok ||
                    got.index !== exp_w.index || got.value !== exp_w.value ||
                    got.last !== exp_w.last) begin
                    fail_count++;
                    $display("%t: expected %0d %0d %0d %h %0d, got %0d %0d %0d %h %0d",
                             $time, exp_w.inertial, exp_w.sum_ok, exp_w.index,
                             exp_w.value, exp_w.last, got.inertial, got.sum_ok,
                             got.index, got.value, got.last);
                end
            end
        end
        if (in_fire)
            deframe_byte(i_s_axis_tdata[7:0]);
    end

    // Ends the run when no word moves on either side for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_count = 0;
        end else begin
            quiet_count++;
            if (quiet_count >= IDLE_LIMIT) begin
                $display("%t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
